// ===== rtl/core/uerc_pkg.sv =====
// uerc_pkg: shared constants and types for the echo ranging controller
// no dependencies; imported by uerc_seq and ultrasonic_echo_ranging_controller

package uerc_pkg;

    localparam int CNT_W  = 16;
    localparam int TRIG_W = 10;
    localparam int DIST_W = 14;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TRIGGER_PULSE = 2'd0;
    localparam logic [IDX_W-1:0] REG_RISE_TIMEOUT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_FALL_TIMEOUT  = 2'd2;
    localparam logic [IDX_W-1:0] REG_MAX_ECHO      = 2'd3;

    localparam logic [TRIG_W-1:0] TRIGGER_PULSE_RST = 10'd10;
    localparam logic [CNT_W-1:0]  RISE_TIMEOUT_RST  = 16'd20000;
    localparam logic [CNT_W-1:0]  FALL_TIMEOUT_RST  = 16'd50000;
    localparam logic [CNT_W-1:0]  MAX_ECHO_RST      = 16'd40438;

    // phase codes
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_TRIGGER   = 2'd1;
    localparam logic [1:0] PH_WAIT_RISE = 2'd2;
    localparam logic [1:0] PH_WAIT_FALL = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_RISE_TIMEOUT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FALL_TIMEOUT = 2'd2;
    localparam logic [STAT_W-1:0] ST_TOO_LONG     = 2'd3;

    localparam logic [0:0] KIND_TICK  = 1'b0;
    localparam logic [0:0] KIND_START = 1'b1;

    // width to mm: floor(w * TICK_NS * 106 / 617176) as multiply and shift
    localparam longint unsigned TICK_NS   = 1000;
    localparam longint unsigned SOUND_NUM = 106;
    localparam longint unsigned SOUND_DEN = 617176;
    localparam int              MM_SHIFT  = 33;
    localparam int              MM_MULT_W = 31;
    localparam longint unsigned MM_MULT_L =
        (TICK_NS * SOUND_NUM * (64'd1 << MM_SHIFT) + SOUND_DEN - 1) / SOUND_DEN;
    localparam logic [MM_MULT_W-1:0] MM_MULT = MM_MULT_W'(MM_MULT_L);
    localparam int              MM_PROD_W = CNT_W + MM_MULT_W;

    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic [STAT_W-1:0] status;
        logic              dist_en;
        logic [CNT_W-1:0]  width;
    } uerc_res_t;

endpackage

// ===== rtl/core/ultrasonic_echo_ranging_controller.sv =====
// ultrasonic_echo_ranging_controller: top level, config registers, two-stage result path
// depends on uerc_pkg and uerc_seq
// result path: an accepted word is registered in stage 1, then in the stage 2 output registers
// throughput: one word per cycle while out_ready does not stall the output; the width-to-mm multiply has its own stage
// reset: registers return to defaults, phase idle, counter zero, both stages empty

module ultrasonic_echo_ranging_controller
    import uerc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic              echo_level,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              trig_level,
    output logic              busy_res,
    output logic              done_res,
    output logic [STAT_W-1:0] status,
    output logic [DIST_W-1:0] range_mm,
    input  logic              cfg_write_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [TRIG_W-1:0]    trig_ticks_reg;
    logic [CNT_W-1:0]     rise_to_reg;
    logic [CNT_W-1:0]     fall_to_reg;
    logic [CNT_W-1:0]     max_echo_reg;

    uerc_res_t            seq_res;
    uerc_res_t            s1_reg;
    logic                 s1_valid_reg;
    logic                 out_valid_reg;
    logic                 out_adv;
    logic                 s1_adv;
    logic                 take;
    logic [MM_PROD_W-1:0] mm_prod;

    logic                 trig_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [DIST_W-1:0]    dist_reg;

    assign out_adv  = !out_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || out_adv;
    assign in_ready = s1_adv;
    assign take     = in_valid && s1_adv;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_ticks_reg <= TRIGGER_PULSE_RST;
            rise_to_reg    <= RISE_TIMEOUT_RST;
            fall_to_reg    <= FALL_TIMEOUT_RST;
            max_echo_reg   <= MAX_ECHO_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_TRIGGER_PULSE: trig_ticks_reg <= cfg_data[TRIG_W-1:0];
                REG_RISE_TIMEOUT:  rise_to_reg    <= cfg_data;
                REG_FALL_TIMEOUT:  fall_to_reg    <= cfg_data;
                REG_MAX_ECHO:      max_echo_reg   <= cfg_data;
                default:           max_echo_reg   <= max_echo_reg;
            endcase
        end
    end

    uerc_seq u_seq (
        .clk                 (clk),
        .rst_n               (rst_n),
        .take                (take),
        .kind                (kind),
        .echo_level          (echo_level),
        .trigger_pulse_ticks (trig_ticks_reg),
        .rise_timeout_ticks  (rise_to_reg),
        .fall_timeout_ticks  (fall_to_reg),
        .max_echo_ticks      (max_echo_reg),
        .res                 (seq_res)
    );

    // stage 1: sequencer result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_reg <= seq_res;
    end

    // stage 2: scale pulse width to mm
    assign mm_prod = MM_PROD_W'(s1_reg.width) * MM_PROD_W'(MM_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            trig_reg   <= s1_reg.trig;
            busy_reg   <= s1_reg.busy;
            done_reg   <= s1_reg.done;
            status_reg <= s1_reg.status;
            dist_reg   <= s1_reg.dist_en ? mm_prod[MM_SHIFT +: DIST_W] : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign trig_level = trig_reg;
    assign busy_res   = busy_reg;
    assign done_res   = done_reg;
    assign status     = status_reg;
    assign range_mm   = dist_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("finished measurement still reports busy");

    a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> done_res)
        else $error("nonzero status without done");

    a_dist_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (range_mm != '0) |-> done_res && (status == ST_OK))
        else $error("distance on a result that is not a good measurement");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_adv |=> s1_valid_reg && $stable(s1_reg))
        else $error("stage 1 word lost while output stalled");

endmodule

// ===== rtl/core/uerc_seq.sv =====
// uerc_seq: measurement phase sequencer and tick counter
// depends on uerc_pkg

module uerc_seq
    import uerc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic              kind,
    input  logic              echo_level,
    input  logic [TRIG_W-1:0] trigger_pulse_ticks,
    input  logic [CNT_W-1:0]  rise_timeout_ticks,
    input  logic [CNT_W-1:0]  fall_timeout_ticks,
    input  logic [CNT_W-1:0]  max_echo_ticks,
    output uerc_res_t         res
);

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_sat;

    assign count_inc = count_reg + 16'd1;
    assign count_sat = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_inc;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        res         = '0;
        if (kind == KIND_START)
        begin
            if (phase_reg == PH_IDLE)
            begin
                phase_next = PH_TRIGGER;
                count_next = '0;
                res.trig   = 1'b1;
            end
            else
            begin
                res.trig = (phase_reg == PH_TRIGGER);
            end
        end
        else
        begin
            case (phase_reg)
                PH_TRIGGER:
                begin
                    res.trig   = 1'b1;
                    count_next = count_inc;
                    if (count_inc >= {{(CNT_W-TRIG_W){1'b0}}, trigger_pulse_ticks})
                    begin
                        phase_next = PH_WAIT_RISE;
                        count_next = '0;
                    end
                end
                PH_WAIT_RISE:
                begin
                    if (echo_level)
                    begin
                        phase_next = PH_WAIT_FALL;
                        count_next = 16'd1;
                    end
                    else
                    begin
                        count_next = count_sat;
                        if (count_sat >= rise_timeout_ticks)
                        begin
                            res.done   = 1'b1;
                            res.status = ST_RISE_TIMEOUT;
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                    end
                end
                PH_WAIT_FALL:
                begin
                    if (!echo_level)
                    begin
                        res.done  = 1'b1;
                        res.width = count_reg;
                        if (count_reg > max_echo_ticks)
                            res.status = ST_TOO_LONG;
                        else
                            res.dist_en = 1'b1;
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_sat;
                        if (count_sat >= fall_timeout_ticks)
                        begin
                            res.done   = 1'b1;
                            res.status = ST_FALL_TIMEOUT;
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        res.busy = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule
